@@ hw/rtl/dft_pkg.sv @@
// Package for the delimited field tokenizer: field widths, character codes,
// default sizes and the record passed from the front end to the back end.
// No dependencies.
`timescale 1ns / 1ps

package dft_pkg;

  localparam int DFT_LINE_LENGTH  = 4096;
  localparam int DFT_QUEUE_DEPTH  = 4;

  localparam int DFT_CHAR_W  = 8;
  localparam int DFT_START_W = 12;
  localparam int DFT_LEN_W   = 13;

  localparam logic [DFT_LEN_W-1:0]  DFT_LEN_MAX       = 13'd8191;
  localparam logic [DFT_CHAR_W-1:0] DFT_DELIM_RESET   = 8'd44;
  localparam logic [DFT_CHAR_W-1:0] DFT_CHAR_SPACE    = 8'd32;
  localparam logic [DFT_CHAR_W-1:0] DFT_CHAR_TAB      = 8'd9;
  localparam logic [DFT_CHAR_W-1:0] DFT_CHAR_NEWLINE  = 8'd10;

  // One queued job: the first result of a character, plus the start of an
  // optional trailing empty field.
  typedef struct packed {
    logic [DFT_START_W-1:0] start;
    logic [DFT_LEN_W-1:0]   length;
    logic [DFT_LEN_W-1:0]   widest;
    logic                   err;
    logic                   done;
    logic                   two;
    logic [DFT_START_W-1:0] start2;
  } dft_entry_t;

endpackage

@@ hw/rtl/delimited_field_tokenizer_unit.sv @@
// Top level of the delimited field tokenizer: front end, job queue, back end.
// Depends on dft_pkg, dft_front, dft_queue and dft_back.
`timescale 1ns / 1ps

// Usage:
// Characters of a line arrive on the in_ channel, one per transaction, with
// in_line_end set on the final character. Each transaction can cause zero,
// one or two result transactions on the out_ channel, each a trimmed field
// given as start and length together with the running widest field. The
// last result caused by one character carries out_run_last.
// The delimiter register is written over the cfg_ channel, which is always
// ready; write it only while the block is idle.
// The front end classifies each character combinationally and writes a
// queue slot at the edge that accepts it; the back end then loads the
// output register from the queue once that register is free or taken.
// Throughput: one character per cycle. The output side moves one result
// per cycle, so a character with two results occupies the back end longer;
// a four-entry job queue absorbs that and short receiver stalls.
// When the receiver stalls long enough to fill the queue, in_ready drops.
// Reset clears the line state and the widest field, and sets the delimiter
// to a comma. There is no clearing pass; the block is ready right after reset.

module delimited_field_tokenizer_unit #(
  parameter int LINE_LENGTH = dft_pkg::DFT_LINE_LENGTH,
  parameter int QUEUE_DEPTH = dft_pkg::DFT_QUEUE_DEPTH
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [dft_pkg::DFT_CHAR_W-1:0]   in_char_code,
  input  logic                             in_line_end,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [dft_pkg::DFT_CHAR_W-1:0]   cfg_delimiter,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [dft_pkg::DFT_START_W-1:0]  out_field_start,
  output logic [dft_pkg::DFT_LEN_W-1:0]    out_field_length,
  output logic [dft_pkg::DFT_LEN_W-1:0]    out_widest_field,
  output logic                             out_is_error,
  output logic                             out_line_done,
  output logic                             out_run_last
);

  // Jobs flow from the front end through the queue to the back end.
  dft_pkg::dft_entry_t push_entry;
  dft_pkg::dft_entry_t pop_entry;
  logic                q_push, q_full, q_pop, q_empty;

  // The front end updates all line state in the cycle a character is taken,
  // so the back end only formats and sequences results.
  dft_front #(
    .LINE_LENGTH(LINE_LENGTH)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_char_code  (in_char_code),
    .in_line_end   (in_line_end),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_delimiter (cfg_delimiter),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_entry       (push_entry)
  );

  dft_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (push_entry),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (pop_entry),
    .empty     (q_empty)
  );

  dft_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_empty          (q_empty),
    .q_entry          (pop_entry),
    .q_pop            (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_field_start  (out_field_start),
    .out_field_length (out_field_length),
    .out_widest_field (out_widest_field),
    .out_is_error     (out_is_error),
    .out_line_done    (out_line_done),
    .out_run_last     (out_run_last)
  );

endmodule

@@ hw/rtl/dft_front.sv @@
// Front end of the tokenizer: accepts characters, tracks the line state and
// the delimiter register, and pushes one job per character that has results.
// Depends on dft_pkg.
`timescale 1ns / 1ps

module dft_front #(
  parameter int LINE_LENGTH = dft_pkg::DFT_LINE_LENGTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [dft_pkg::DFT_CHAR_W-1:0]  in_char_code,
  input  logic                            in_line_end,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [dft_pkg::DFT_CHAR_W-1:0]  cfg_delimiter,
  input  logic                            q_full,
  output logic                            q_push,
  output dft_pkg::dft_entry_t             q_entry
);

  localparam int PW    = $clog2(LINE_LENGTH + 1);
  localparam int SEXTW = (PW > dft_pkg::DFT_START_W) ? PW : dft_pkg::DFT_START_W;
  localparam int LEXTW = (PW > dft_pkg::DFT_LEN_W) ? PW : dft_pkg::DFT_LEN_W;
  localparam logic [PW-1:0] LINE_MAX = PW'(LINE_LENGTH);
  localparam logic [PW-1:0] ONE      = PW'(1);

  logic [dft_pkg::DFT_CHAR_W-1:0] delim_r;
  logic [PW-1:0] pos_r, pos_nxt;
  logic [PW-1:0] fstart_r, fstart_nxt;
  logic [PW-1:0] first_r, first_nxt;
  logic [PW-1:0] last_r, last_nxt;
  logic [PW-1:0] maxw_r, maxw_nxt;
  logic          seen_r, seen_nxt;
  logic          stopped_r, stopped_nxt;

  logic          accept;
  logic          is_delim, is_nl, is_blank, too_long, kept;
  logic          seen_u;
  logic [PW-1:0] first_u, last_u, f_len, f_start, maxw_u, pos_inc;
  logic [PW-1:0] r_start, r_len, r_widest;
  logic          r_emit, r_err, r_done, r_two;
  logic [SEXTW-1:0] s_ext, s2_ext;
  logic [LEXTW-1:0] l_ext, w_ext;

  assign in_ready  = !q_full;
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;

  always_comb begin
    is_delim = (in_char_code == delim_r);
    is_nl    = (in_char_code == dft_pkg::DFT_CHAR_NEWLINE);
    is_blank = (in_char_code == dft_pkg::DFT_CHAR_SPACE) ||
               (in_char_code == dft_pkg::DFT_CHAR_TAB);
    too_long = (pos_r >= LINE_MAX);
    kept     = !stopped_r && !too_long && !is_delim && !is_blank;
    pos_inc  = pos_r + ONE;

    // Trim bounds with this character folded in; unchanged unless kept.
    seen_u  = seen_r || kept;
    first_u = (kept && !seen_r) ? pos_r : first_r;
    last_u  = kept ? pos_r : last_r;
    f_len   = seen_u ? (last_u - first_u + ONE) : '0;
    f_start = seen_u ? first_u : fstart_r;
    maxw_u  = (f_len > maxw_r) ? f_len : maxw_r;

    r_emit   = 1'b0;
    r_start  = fstart_r;
    r_len    = '0;
    r_widest = maxw_r;
    r_err    = 1'b0;
    r_done   = 1'b0;
    r_two    = 1'b0;

    pos_nxt     = pos_r;
    fstart_nxt  = fstart_r;
    first_nxt   = first_r;
    last_nxt    = last_r;
    seen_nxt    = seen_r;
    stopped_nxt = stopped_r;
    maxw_nxt    = maxw_r;

    if (accept) begin
      if (!stopped_r) begin
        if (too_long || (is_delim && (pos_r == fstart_r))) begin
          r_emit      = 1'b1;
          r_err       = 1'b1;
          r_done      = 1'b1;
          stopped_nxt = 1'b1;
        end else if (is_delim) begin
          r_emit     = 1'b1;
          r_start    = f_start;
          r_len      = f_len;
          r_widest   = maxw_u;
          r_done     = is_nl;
          maxw_nxt   = maxw_u;
          fstart_nxt = pos_inc;
          seen_nxt   = 1'b0;
          if (is_nl) begin
            stopped_nxt = 1'b1;
          end else if (in_line_end) begin
            r_two       = 1'b1;
            stopped_nxt = 1'b1;
          end
        end else begin
          seen_nxt  = seen_u;
          first_nxt = first_u;
          last_nxt  = last_u;
          if (in_line_end) begin
            r_emit      = 1'b1;
            r_start     = f_start;
            r_len       = f_len;
            r_widest    = maxw_u;
            r_done      = 1'b1;
            maxw_nxt    = maxw_u;
            stopped_nxt = 1'b1;
          end
        end
      end

      if (in_line_end) begin
        pos_nxt     = '0;
        fstart_nxt  = '0;
        first_nxt   = '0;
        last_nxt    = '0;
        seen_nxt    = 1'b0;
        stopped_nxt = 1'b0;
      end else if (pos_r < LINE_MAX) begin
        pos_nxt = pos_inc;
      end
    end
  end

  // Pack the job: positions masked to the port width, lengths saturated.
  always_comb begin
    s_ext  = SEXTW'(r_start);
    s2_ext = SEXTW'(pos_inc);
    l_ext  = LEXTW'(r_len);
    w_ext  = LEXTW'(r_widest);
    q_entry.start  = s_ext[dft_pkg::DFT_START_W-1:0];
    q_entry.start2 = s2_ext[dft_pkg::DFT_START_W-1:0];
    q_entry.length = (l_ext > LEXTW'(dft_pkg::DFT_LEN_MAX)) ? dft_pkg::DFT_LEN_MAX :
                     l_ext[dft_pkg::DFT_LEN_W-1:0];
    q_entry.widest = (w_ext > LEXTW'(dft_pkg::DFT_LEN_MAX)) ? dft_pkg::DFT_LEN_MAX :
                     w_ext[dft_pkg::DFT_LEN_W-1:0];
    q_entry.err    = r_err;
    q_entry.done   = r_done;
    q_entry.two    = r_two;
    q_push         = r_emit;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delim_r   <= dft_pkg::DFT_DELIM_RESET;
      pos_r     <= '0;
      fstart_r  <= '0;
      first_r   <= '0;
      last_r    <= '0;
      maxw_r    <= '0;
      seen_r    <= 1'b0;
      stopped_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        delim_r <= cfg_delimiter;
      end
      pos_r     <= pos_nxt;
      fstart_r  <= fstart_nxt;
      first_r   <= first_nxt;
      last_r    <= last_nxt;
      maxw_r    <= maxw_nxt;
      seen_r    <= seen_nxt;
      stopped_r <= stopped_nxt;
    end
  end

  // A stopped line produces nothing until its final character clears it.
  a_stopped_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && stopped_r) |-> !q_push)
    else $error("result produced after the line stopped");

  // The character position saturates at the line limit.
  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= LINE_MAX)
    else $error("character position beyond the line limit");

endmodule

@@ hw/rtl/dft_queue.sv @@
// Short register queue of jobs between the tokenizer front end and back end.
// Depends on dft_pkg.
`timescale 1ns / 1ps

module dft_queue #(
  parameter int DEPTH = dft_pkg::DFT_QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  dft_pkg::dft_entry_t push_data,
  output logic                full,
  input  logic                pop,
  output dft_pkg::dft_entry_t pop_data,
  output logic                empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  dft_pkg::dft_entry_t slot_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          do_push, do_pop;

  assign full     = (cnt_r == CNT_FULL);
  assign empty    = (cnt_r == '0);
  assign pop_data = slot_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_IDX) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_IDX) ? '0 : rd_ptr_r + AW'(1);
    end
    case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + CW'(1);
      2'b01:   cnt_nxt = cnt_r - CW'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // The front end only pushes while space is left.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full)
    else $error("job pushed into a full queue");

endmodule

@@ hw/rtl/dft_back.sv @@
// Back end of the tokenizer: pops jobs and presents their one or two results
// from an output register. Depends on dft_pkg.
`timescale 1ns / 1ps

module dft_back (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             q_empty,
  input  dft_pkg::dft_entry_t              q_entry,
  output logic                             q_pop,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [dft_pkg::DFT_START_W-1:0]  out_field_start,
  output logic [dft_pkg::DFT_LEN_W-1:0]    out_field_length,
  output logic [dft_pkg::DFT_LEN_W-1:0]    out_widest_field,
  output logic                             out_is_error,
  output logic                             out_line_done,
  output logic                             out_run_last
);

  logic                            out_valid_r, out_valid_nxt;
  logic                            pend_r, pend_nxt;
  logic [dft_pkg::DFT_START_W-1:0] start_r, start_nxt;
  logic [dft_pkg::DFT_START_W-1:0] start2_r, start2_nxt;
  logic [dft_pkg::DFT_LEN_W-1:0]   len_r, len_nxt;
  logic [dft_pkg::DFT_LEN_W-1:0]   widest_r, widest_nxt;
  logic                            err_r, err_nxt;
  logic                            done_r, done_nxt;
  logic                            last_r, last_nxt;
  logic                            advance;

  assign advance = !out_valid_r || out_ready;
  assign q_pop   = advance && !pend_r && !q_empty;

  always_comb begin
    out_valid_nxt = out_valid_r;
    pend_nxt      = pend_r;
    start_nxt     = start_r;
    start2_nxt    = start2_r;
    len_nxt       = len_r;
    widest_nxt    = widest_r;
    err_nxt       = err_r;
    done_nxt      = done_r;
    last_nxt      = last_r;
    if (advance) begin
      if (pend_r) begin
        // Trailing empty field after a delimiter on the final character.
        out_valid_nxt = 1'b1;
        pend_nxt      = 1'b0;
        start_nxt     = start2_r;
        len_nxt       = '0;
        err_nxt       = 1'b0;
        done_nxt      = 1'b1;
        last_nxt      = 1'b1;
      end else if (!q_empty) begin
        out_valid_nxt = 1'b1;
        pend_nxt      = q_entry.two;
        start_nxt     = q_entry.start;
        start2_nxt    = q_entry.start2;
        len_nxt       = q_entry.length;
        widest_nxt    = q_entry.widest;
        err_nxt       = q_entry.err;
        done_nxt      = q_entry.done;
        last_nxt      = !q_entry.two;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    start_r  <= start_nxt;
    start2_r <= start2_nxt;
    len_r    <= len_nxt;
    widest_r <= widest_nxt;
    err_r    <= err_nxt;
    done_r   <= done_nxt;
    last_r   <= last_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_field_start  = start_r;
  assign out_field_length = len_r;
  assign out_widest_field = widest_r;
  assign out_is_error     = err_r;
  assign out_line_done    = done_r;
  assign out_run_last     = last_r;

  // A pending second result always sits behind a shown first result.
  a_pend_shown: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> out_valid_r)
    else $error("second result pending without a first one shown");

  // Taking a first-of-two result brings the closing empty field next.
  a_second_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_ready && !last_r) |=>
      (out_valid_r && last_r && done_r && (len_r == '0)))
    else $error("second result of a character did not follow");

endmodule

@@ bench/tb_delimited_field_tokenizer_unit.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for delimited_field_tokenizer_unit: directed and random lines,
// an independent field predictor and an in-order result scoreboard.
// Depends on dft_pkg and the tokenizer RTL.

module tb_delimited_field_tokenizer_unit;

  localparam int LINE_LEN            = dft_pkg::DFT_LINE_LENGTH;
  // Settling time after every character is taken and every result checked.
  localparam int SETTLE_CYCLES       = 6;
  localparam int WATCHDOG_LIMIT      = 2000;
  localparam int BACKPRESSURE_CYCLES = 80;
  localparam int RANDOM_PER_PHASE    = 115;

  typedef struct {
    logic [dft_pkg::DFT_CHAR_W-1:0] code;
    logic                           line_end;
  } char_item_t;

  typedef struct {
    logic [dft_pkg::DFT_START_W-1:0] start;
    logic [dft_pkg::DFT_LEN_W-1:0]   length;
    logic [dft_pkg::DFT_LEN_W-1:0]   widest;
    logic                            err;
    logic                            done;
    logic                            run_last;
  } field_result_t;

  // Every input of the block starts at a known value.
  logic                            clk           = 1'b0;
  logic                            rst_n         = 1'b0;
  logic                            in_valid      = 1'b0;
  logic [dft_pkg::DFT_CHAR_W-1:0]  in_char_code  = '0;
  logic                            in_line_end   = 1'b0;
  logic                            cfg_valid     = 1'b0;
  logic [dft_pkg::DFT_CHAR_W-1:0]  cfg_delimiter = dft_pkg::DFT_DELIM_RESET;
  logic                            out_ready     = 1'b0;
  logic                            in_ready;
  logic                            cfg_ready;
  logic                            out_valid;
  logic [dft_pkg::DFT_START_W-1:0] out_field_start;
  logic [dft_pkg::DFT_LEN_W-1:0]   out_field_length;
  logic [dft_pkg::DFT_LEN_W-1:0]   out_widest_field;
  logic                            out_is_error;
  logic                            out_line_done;
  logic                            out_run_last;

  // Stimulus bookkeeping. The queue of pending characters feeds the driver;
  // the two counters tell the sequencer when every character has gone in.
  char_item_t                     chars_to_send[$];
  char_item_t                     next_char;
  logic [dft_pkg::DFT_CHAR_W-1:0] line_chars[$];
  int                             chars_queued = 0;
  int                             chars_taken  = 0;
  int                             send_idle_pct = 0;
  int                             recv_idle_pct = 0;

  // Results still owed by the block, oldest first.
  field_result_t                  fields_due[$];
  int                             fail_count = 0;

  // Receiver hold-off and watchdog.
  int                             hold_left    = 0;
  logic                           hold_done    = 1'b0;
  int                             quiet_cycles = 0;

  // Predictor copy of the delimiter register and of the line state. Start
  // registers are one bit wider than the port so that the position just past
  // the line limit is kept exactly; the port value is the low 12 bits.
  logic [dft_pkg::DFT_CHAR_W-1:0] model_delim    = dft_pkg::DFT_DELIM_RESET;
  logic [dft_pkg::DFT_LEN_W-1:0]  line_pos       = '0;
  logic [dft_pkg::DFT_LEN_W-1:0]  field_begin    = '0;
  logic [dft_pkg::DFT_LEN_W-1:0]  first_kept_pos = '0;
  logic [dft_pkg::DFT_LEN_W-1:0]  last_kept_pos  = '0;
  logic                           kept_any       = 1'b0;
  logic                           line_halted    = 1'b0;
  logic [dft_pkg::DFT_LEN_W-1:0]  widest_seen    = '0;

  delimited_field_tokenizer_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_char_code     (in_char_code),
    .in_line_end      (in_line_end),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_delimiter    (cfg_delimiter),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_field_start  (out_field_start),
    .out_field_length (out_field_length),
    .out_widest_field (out_widest_field),
    .out_is_error     (out_is_error),
    .out_line_done    (out_line_done),
    .out_run_last     (out_run_last)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  function automatic field_result_t make_result(
      input logic [dft_pkg::DFT_LEN_W-1:0] start,
      input logic [dft_pkg::DFT_LEN_W-1:0] len,
      input logic err, input logic done);
    field_result_t r;
    r.start    = start[dft_pkg::DFT_START_W-1:0];
    r.length   = len;
    r.widest   = widest_seen;
    r.err      = err;
    r.done     = done;
    r.run_last = 1'b0;
    return r;
  endfunction

  // Closes the field collected so far. A field with no kept character is
  // reported at the place where it began, with length zero.
  function automatic field_result_t close_field(input logic done);
    logic [dft_pkg::DFT_LEN_W-1:0] start;
    logic [dft_pkg::DFT_LEN_W-1:0] len;
    start = field_begin;
    len   = '0;
    if (kept_any) begin
      start = first_kept_pos;
      len   = last_kept_pos - first_kept_pos + 13'd1;
    end
    if (len > widest_seen) widest_seen = len;
    return make_result(start, len, 1'b0, done);
  endfunction

  // Advances the predicted line state by one accepted character and queues
  // the zero, one or two results it causes.
  task automatic predict_char(input logic [dft_pkg::DFT_CHAR_W-1:0] ch, input logic last);
    field_result_t                 res[2];
    int                            n;
    logic [dft_pkg::DFT_LEN_W-1:0] p;
    logic                          nl;
    n = 0;
    p = line_pos;
    if (!line_halted) begin
      if (p >= LINE_LEN) begin
        // The line ran past its limit: one error, the rest is skipped.
        res[n] = make_result(field_begin, '0, 1'b1, 1'b1);
        n++;
        line_halted = 1'b1;
      end else if (ch == model_delim) begin
        if (p == field_begin) begin
          // A delimiter where a field should begin stops the line.
          res[n] = make_result(field_begin, '0, 1'b1, 1'b1);
          n++;
          line_halted = 1'b1;
        end else begin
          nl = (ch == dft_pkg::DFT_CHAR_NEWLINE);
          res[n] = close_field(nl);
          n++;
          field_begin = p + 13'd1;
          kept_any    = 1'b0;
          if (nl) begin
            // A newline delimiter ends the line with the field it closes.
            line_halted = 1'b1;
          end else if (last) begin
            // A trailing delimiter opens one more, empty, final field.
            res[n] = make_result(field_begin, '0, 1'b0, 1'b1);
            n++;
            line_halted = 1'b1;
          end
        end
      end else begin
        if (ch != dft_pkg::DFT_CHAR_SPACE && ch != dft_pkg::DFT_CHAR_TAB) begin
          if (!kept_any) begin
            first_kept_pos = p;
            kept_any       = 1'b1;
          end
          last_kept_pos = p;
        end
        if (last) begin
          res[n] = close_field(1'b1);
          n++;
          line_halted = 1'b1;
        end
      end
    end
    for (int i = 0; i < n; i++) begin
      if (i == n - 1) res[i].run_last = 1'b1;
      fields_due.push_back(res[i]);
    end
    if (last) begin
      line_pos       = '0;
      field_begin    = '0;
      first_kept_pos = '0;
      last_kept_pos  = '0;
      kept_any       = 1'b0;
      line_halted    = 1'b0;
    end else if (line_pos < LINE_LEN) begin
      line_pos = p + 13'd1;
    end
  endtask

  // ---------------------------------------------------------------------
  // Driver: takes the next character from the pending queue whenever the
  // channel is free, and idles at random as the current phase asks. The
  // character in flight is predicted at the edge where it is accepted.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        predict_char(in_char_code, in_line_end);
        chars_taken = chars_taken + 1;
      end
      if (!in_valid || in_ready) begin
        if (chars_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_char     = chars_to_send.pop_front();
          in_valid     <= 1'b1;
          in_char_code <= next_char.code;
          in_line_end  <= next_char.line_end;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: checks every accepted result against the oldest expectation.
  // In the first phase without random idling it holds off once for a long
  // stretch, so that the job queue fills and the block stops taking input.
  // ---------------------------------------------------------------------

  function automatic void compare_field(input string name,
                                        input logic [dft_pkg::DFT_LEN_W-1:0] want,
                                        input logic [dft_pkg::DFT_LEN_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      fail_count++;
    end
  endfunction

  task automatic check_result();
    field_result_t want;
    if (fields_due.size() == 0) begin
      $error("result with no expectation waiting: field_start %0d field_length %0d",
             out_field_start, out_field_length);
      fail_count++;
    end else begin
      want = fields_due.pop_front();
      compare_field("field_start", want.start, out_field_start);
      compare_field("field_length", want.length, out_field_length);
      compare_field("widest_field", want.widest, out_widest_field);
      compare_field("is_error", want.err, out_is_error);
      compare_field("line_done", want.done, out_line_done);
      compare_field("run_last", want.run_last, out_run_last);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) check_result();
      if (hold_left != 0) begin
        out_ready <= 1'b0;
        hold_left <= hold_left - 1;
      end else if (!hold_done && send_idle_pct == 0 && recv_idle_pct == 0 && out_valid) begin
        out_ready <= 1'b0;
        hold_left <= BACKPRESSURE_CYCLES;
        hold_done <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog: ends the run when no transaction of any kind has moved for a
  // long time. The longest legal quiet stretch is the receiver hold-off.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------

  task automatic add_char(input logic [dft_pkg::DFT_CHAR_W-1:0] c);
    line_chars.push_back(c);
  endtask

  // Moves the line under construction to the driver, flagging its final
  // character as the line end.
  task automatic end_line();
    char_item_t item;
    for (int i = 0; i < line_chars.size(); i++) begin
      item.code     = line_chars[i];
      item.line_end = (i == line_chars.size() - 1);
      chars_to_send.push_back(item);
    end
    chars_queued = chars_queued + line_chars.size();
    line_chars.delete();
  endtask

  // Any byte that is neither a blank nor the current delimiter.
  function automatic logic [dft_pkg::DFT_CHAR_W-1:0] pick_text();
    logic [dft_pkg::DFT_CHAR_W-1:0] c;
    do c = dft_pkg::DFT_CHAR_W'($urandom_range(255));
    while (c == model_delim || c == dft_pkg::DFT_CHAR_SPACE || c == dft_pkg::DFT_CHAR_TAB);
    return c;
  endfunction

  // A space or a tab, whichever is not the delimiter.
  function automatic logic [dft_pkg::DFT_CHAR_W-1:0] pick_blank();
    logic [dft_pkg::DFT_CHAR_W-1:0] c;
    c = $urandom_range(1) ? dft_pkg::DFT_CHAR_SPACE : dft_pkg::DFT_CHAR_TAB;
    if (c == model_delim) begin
      c = (c == dft_pkg::DFT_CHAR_SPACE) ? dft_pkg::DFT_CHAR_TAB : dft_pkg::DFT_CHAR_SPACE;
    end
    return c;
  endfunction

  // A well-formed line: blank-padded fields with random text, now and then
  // an empty field (which the block reports as an error unless it ends the
  // line) or a trailing delimiter.
  task automatic add_random_line();
    int n_fields;
    n_fields = $urandom_range(1, 5);
    for (int f = 0; f < n_fields; f++) begin
      if (f != 0) add_char(model_delim);
      if ($urandom_range(15) == 0) continue;
      repeat ($urandom_range(2)) add_char(pick_blank());
      repeat ($urandom_range(6)) add_char(($urandom_range(4) == 0) ? pick_blank() : pick_text());
      repeat ($urandom_range(2)) add_char(pick_blank());
    end
    if ($urandom_range(4) == 0) add_char(model_delim);
    if (line_chars.size() == 0) add_char(pick_text());
    end_line();
  endtask

  // Raw bytes with line ends at random places.
  task automatic add_noise();
    char_item_t item;
    repeat ($urandom_range(1, 8)) begin
      item.code     = dft_pkg::DFT_CHAR_W'($urandom_range(255));
      item.line_end = ($urandom_range(7) == 0);
      chars_to_send.push_back(item);
      chars_queued++;
    end
  endtask

  task automatic add_random_chars(input int count);
    int target;
    target = chars_queued + count;
    while (chars_queued < target) begin
      if ($urandom_range(6) == 0) add_noise();
      else add_random_line();
    end
  endtask

  // Waits until every character has been taken and every result checked,
  // then lets the pipeline settle.
  task automatic wait_idle();
    while (chars_taken != chars_queued || fields_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // The delimiter is only ever written while the block is idle, so the
  // predictor copy is updated at the handshake.
  task automatic write_delimiter(input logic [dft_pkg::DFT_CHAR_W-1:0] value);
    @(posedge clk);
    cfg_valid     <= 1'b1;
    cfg_delimiter <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid   <= 1'b0;
    model_delim  = value;
  endtask

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Sender idles about a third of the time, the receiver a little under
    // half of it.
    send_idle_pct = 34;
    recv_idle_pct = 45;

    // Directed lines with the reset delimiter (comma). A padded field with
    // inner blank, an all-blank field, a one-character field, then a
    // trailing delimiter giving an empty final field.
    add_char(dft_pkg::DFT_CHAR_SPACE); add_char("a");
    add_char(dft_pkg::DFT_CHAR_SPACE); add_char("b");
    add_char(dft_pkg::DFT_CHAR_SPACE); add_char(model_delim);
    add_char(dft_pkg::DFT_CHAR_TAB);
    add_char(model_delim); add_char("x"); add_char(model_delim);
    end_line();
    // Delimiter as the very first character; the rest of the line is skipped.
    add_char(model_delim); add_char("z");
    end_line();
    // Two delimiters in a row.
    add_char("q"); add_char(model_delim); add_char(model_delim); add_char("r");
    end_line();
    // Extreme byte values as field text.
    add_char(8'hFF); add_char(8'h00);
    end_line();
    // A line that is one blank only.
    add_char(dft_pkg::DFT_CHAR_TAB);
    end_line();
    wait_idle();

    // Newline as delimiter: it closes its field and ends the line, whether
    // or not it is the final character.
    write_delimiter(dft_pkg::DFT_CHAR_NEWLINE);
    add_char("a"); add_char("b"); add_char(dft_pkg::DFT_CHAR_NEWLINE);
    end_line();
    add_char("c"); add_char(dft_pkg::DFT_CHAR_NEWLINE); add_char("d");
    end_line();
    add_random_chars(RANDOM_PER_PHASE);
    wait_idle();

    // Swap the idling of the two sides and visit both delimiter extremes.
    send_idle_pct = 45;
    recv_idle_pct = 34;
    write_delimiter(8'h00);
    add_random_chars(RANDOM_PER_PHASE);
    wait_idle();
    write_delimiter(8'hFF);
    add_random_chars(RANDOM_PER_PHASE);
    wait_idle();

    // No idling from here on; the monitor's one long hold-off falls here.
    // Space as delimiter leaves only tab as a blank.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_delimiter(dft_pkg::DFT_CHAR_SPACE);
    add_random_chars(RANDOM_PER_PHASE);
    wait_idle();
    write_delimiter(dft_pkg::DFT_CHAR_W'($urandom_range(255)));
    add_random_chars(RANDOM_PER_PHASE);
    wait_idle();

    // Back to the reset delimiter for a couple of closing lines.
    write_delimiter(dft_pkg::DFT_DELIM_RESET);
    add_random_line();
    add_random_line();
    wait_idle();

    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
